FILE: hdl/dxt_texture_block_decoder_defines.svh
// Assertion macros for the DXT block decoder.
// Taken in by the top level; expects clk and rst_n in scope.
`ifndef DXT_TEXTURE_BLOCK_DECODER_DEFINES_SVH
`define DXT_TEXTURE_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define DXT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DXT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dxt_pkg.sv
// Shared types, format codes and arithmetic helpers for the DXT block decoder.
// No dependencies.
package dxt_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam int TEXELS = 16;
  localparam int COLS   = 4;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef logic [31:0] texel_t;
  typedef logic [TEXELS-1:0][31:0] tex_blk_t;

  // palette sums, registered between the two arithmetic stages
  // channel index 2 = red, 1 = green, 0 = blue
  typedef struct packed {
    logic [1:0]        fmt;
    logic              three;
    logic [31:0]       cidx;
    logic [63:0]       alpha;
    logic [2:0][7:0]   ep0;
    logic [2:0][7:0]   ep1;
    logic [2:0][9:0]   sum21;
    logic [2:0][9:0]   sum12;
    logic [2:0][8:0]   sum11;
    logic              a_gt;
    logic [7:2][10:0]  a_sum;
  } dxt_sums_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x/3 for x <= 765: 683/2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'b0, x} * 21'd683;
    return p[18:11];
  endfunction

  // x/5 for x <= 1275: 3277/16384
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'b0, x} * 23'd3277;
    return p[21:14];
  endfunction

  // x/7 for x <= 1785: 2341/16384
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'b0, x} * 23'd2341;
    return p[21:14];
  endfunction

endpackage

FILE: hdl/dxt_blend_sums.sv
// First arithmetic stage: endpoint widening and weighted palette sums.
// Depends on dxt_pkg.
module dxt_blend_sums (
  input  logic [63:0]       color_half,
  input  logic [63:0]       alpha_half,
  input  logic [1:0]        fmt,
  output dxt_pkg::dxt_sums_t sums
);
  import dxt_pkg::*;

  logic [15:0]     c0;
  logic [15:0]     c1;
  logic [2:0][7:0] ep0;
  logic [2:0][7:0] ep1;
  logic [7:0]      a0;
  logic [7:0]      a1;
  logic            a_gt;

  assign c0 = color_half[15:0];
  assign c1 = color_half[31:16];
  assign ep0 = {widen5(c0[15:11]), widen6(c0[10:5]), widen5(c0[4:0])};
  assign ep1 = {widen5(c1[15:11]), widen6(c1[10:5]), widen5(c1[4:0])};
  assign a0 = alpha_half[7:0];
  assign a1 = alpha_half[15:8];
  assign a_gt = a0 > a1;

  assign sums.fmt   = fmt;
  assign sums.three = (fmt == FMT_DXT1) && (c0 <= c1);
  assign sums.cidx  = color_half[63:32];
  assign sums.alpha = alpha_half;
  assign sums.ep0   = ep0;
  assign sums.ep1   = ep1;
  assign sums.a_gt  = a_gt;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    assign sums.sum21[ch] = 10'({ep0[ch], 1'b0}) + 10'(ep1[ch]);
    assign sums.sum12[ch] = 10'(ep0[ch]) + 10'({ep1[ch], 1'b0});
    assign sums.sum11[ch] = 9'(ep0[ch]) + 9'(ep1[ch]);
  end

  // eight-entry weights (8-i, i-1); six-entry weights (6-i, i-1), top two unused
  for (genvar i = 2; i < 8; i++) begin : g_asum
    localparam int W0G = 8 - i;
    localparam int W0L = (i < 6) ? (6 - i) : 0;
    localparam int W1  = i - 1;
    logic [10:0] w0;
    assign w0 = a_gt ? 11'(W0G) : 11'(W0L);
    assign sums.a_sum[i] = ({3'b0, a0} * w0) + ({3'b0, a1} * 11'(W1));
  end

endmodule

FILE: hdl/dxt_texel_sel.sv
// Second arithmetic stage: blend division, palette build and per-texel lookup.
// Depends on dxt_pkg.
module dxt_texel_sel (
  input  dxt_pkg::dxt_sums_t sums,
  output dxt_pkg::tex_blk_t  texels
);
  import dxt_pkg::*;

  logic [3:0][2:0][7:0] cpal;
  logic [7:0][7:0]      apal;

  assign cpal[0] = sums.ep0;
  assign cpal[1] = sums.ep1;

  for (genvar ch = 0; ch < 3; ch++) begin : g_cpal
    assign cpal[2][ch] = sums.three ? sums.sum11[ch][8:1] : div3(sums.sum21[ch]);
    assign cpal[3][ch] = sums.three ? 8'h00 : div3(sums.sum12[ch]);
  end

  assign apal[0] = sums.alpha[7:0];
  assign apal[1] = sums.alpha[15:8];

  for (genvar i = 2; i < 8; i++) begin : g_apal
    if (i < 6) begin : g_mid
      assign apal[i] = sums.a_gt ? div7(sums.a_sum[i]) : div5(sums.a_sum[i]);
    end else if (i == 6) begin : g_six
      assign apal[i] = sums.a_gt ? div7(sums.a_sum[i]) : ALPHA_CLEAR;
    end else begin : g_sev
      assign apal[i] = sums.a_gt ? div7(sums.a_sum[i]) : ALPHA_OPAQUE;
    end
  end

  for (genvar t = 0; t < TEXELS; t++) begin : g_tex
    logic [1:0] ci;
    logic [2:0] ai;
    logic [3:0] nib;
    logic [7:0] a_byte;

    assign ci  = sums.cidx[2*t +: 2];
    assign ai  = sums.alpha[16 + 3*t +: 3];
    assign nib = sums.alpha[4*t +: 4];

    // transparent black only in the three-colour palette
    always_comb begin
      unique case (sums.fmt)
        FMT_DXT1: a_byte = (sums.three && (ci == 2'd3)) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        FMT_DXT3: a_byte = {nib, nib};
        default:  a_byte = apal[ai];
      endcase
    end

    assign texels[t] = {a_byte, cpal[ci]};
  end

endmodule

FILE: hdl/dxt_texture_block_decoder.sv
// DXT1/DXT3/DXT5 block decoder top level: input register, two arithmetic
// stages and a row serialiser. Depends on dxt_pkg, dxt_blend_sums,
// dxt_texel_sel and dxt_texture_block_decoder_defines.svh.
//
// Usage:
//   cfg_*  : write block_format (0 DXT1, 1 DXT3, 2 or 3 DXT5) while idle.
//            cfg_ready is always high.
//   in_*   : one compressed 4x4 block per word (colour half, alpha half).
//   out_*  : four words per block, rows 0..3 in order, out_last_row on row 3.
// Path: a block accepted into the input register moves through the sums
//   register into the row register, which puts its first row on out_*; the
//   other rows follow on consecutive cycles if out_ready stays high.
// Flow: the output serialiser hands out one row per cycle while out_ready
//   is high and holds each block for its four rows; the input and sums
//   registers ahead of it take new words meanwhile, while there is room.
// Reset: all stage valids clear, block_format returns to DXT1.
// Stall: a low out_ready holds the current row; the stages behind it fill
//   up one by one and in_ready falls once all are occupied. Nothing is
//   dropped or repeated.
`include "dxt_texture_block_decoder_defines.svh"

module dxt_texture_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_block_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_color_half,
  input  logic [63:0] in_alpha_half,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row_number,
  output logic [31:0] out_texel_col0,
  output logic [31:0] out_texel_col1,
  output logic [31:0] out_texel_col2,
  output logic [31:0] out_texel_col3,
  output logic        out_last_row
);
  import dxt_pkg::*;

  logic [1:0]  fmt_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic [63:0] s1_color_r;
  logic [63:0] s1_alpha_r;
  logic [1:0]  s1_fmt_r;

  logic        s2_valid_r, s2_valid_nxt;
  dxt_sums_t   s2_r;
  dxt_sums_t   sums;

  logic        s3_valid_r, s3_valid_nxt;
  logic [1:0]  row_r, row_nxt;
  tex_blk_t    tex_r;
  tex_blk_t    texels;

  logic s1_ready, s2_ready, s3_ready;
  logic s1_load, s2_load, s3_load;
  logic row_last, row_step;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_block_format;
    end
  end

  // stage flow
  assign row_last = (row_r == ROW_LAST);
  assign row_step = s3_valid_r && out_ready;
  assign s3_ready = !s3_valid_r || (out_ready && row_last);
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  assign s1_load = in_valid && s1_ready;
  assign s2_load = s1_valid_r && s2_ready;
  assign s3_load = s2_valid_r && s3_ready;

  always_comb begin
    s1_valid_nxt = s1_load || (s1_valid_r && !s2_ready);
    s2_valid_nxt = s2_load || (s2_valid_r && !s3_ready);
    s3_valid_nxt = s3_load || (s3_valid_r && !(out_ready && row_last));
    priority if (s3_load) begin
      row_nxt = ROW_FIRST;
    end else if (row_step && !row_last) begin
      row_nxt = row_r + 2'd1;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      row_r      <= ROW_FIRST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
      row_r      <= row_nxt;
    end
  end

  // payload
  dxt_blend_sums u_sums (
    .color_half (s1_color_r),
    .alpha_half (s1_alpha_r),
    .fmt        (s1_fmt_r),
    .sums       (sums)
  );

  dxt_texel_sel u_sel (
    .sums   (s2_r),
    .texels (texels)
  );

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_color_r <= in_color_half;
      s1_alpha_r <= in_alpha_half;
      s1_fmt_r   <= fmt_r;
    end
    if (s2_load) begin
      s2_r <= sums;
    end
    // serialiser: row shifts down into column slots 0..3
    if (s3_load) begin
      tex_r <= texels;
    end else if (row_step && !row_last) begin
      tex_r <= tex_r >> (COLS * 32);
    end
  end

  assign out_valid      = s3_valid_r;
  assign out_row_number = row_r;
  assign out_last_row   = row_last;
  assign out_texel_col0 = tex_r[0];
  assign out_texel_col1 = tex_r[1];
  assign out_texel_col2 = tex_r[2];
  assign out_texel_col3 = tex_r[3];

  `DXT_ASSERT_NEXT(a_row_advance,
    out_valid && out_ready && !out_last_row,
    out_valid && (out_row_number == $past(out_row_number) + 2'd1),
    "row did not advance")
  `DXT_ASSERT_NEXT(a_load_first_row,
    s3_load,
    out_valid && (out_row_number == ROW_FIRST),
    "new block did not start at row 0")
  `DXT_ASSERT_NEXT(a_drain,
    out_valid && out_ready && out_last_row && !s2_valid_r,
    !out_valid,
    "output valid after last row with nothing behind it")

endmodule

FILE: test/tb_dxt_texture_block_decoder.sv
// Self-checking testbench for dxt_texture_block_decoder: directed and random blocks in
// every format, with random stalls on both sides. Needs dxt_pkg and the RTL under hdl/.
module tb_dxt_texture_block_decoder;
  import dxt_pkg::*;

  // spare code: the high bit alone selects interpolated alpha
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 56;
  localparam int LIMIT_TIME    = 2000000;

  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] texel;
    logic             last;
  } texel_row_t;

  class texel_row_board;
    texel_row_t rows_due[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function logic [31:0] expand565(input logic [15:0] c);
      return {ALPHA_OPAQUE, c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
    endfunction

    // truncating weighted mean, byte by byte
    function logic [31:0] mix(input logic [31:0] p, q, input int wp, wq, dv);
      logic [31:0] res;
      int a, b, s;
      res = '0;
      for (s = 0; s < 32; s += 8) begin
        a = p[s +: 8];
        b = q[s +: 8];
        res[s +: 8] = 8'((a * wp + b * wq) / dv);
      end
      return res;
    endfunction

    function int alpha_level(input int a0, a1, ai);
      if (ai == 0) return a0;
      if (ai == 1) return a1;
      if (a0 > a1) return ((8 - ai) * a0 + (ai - 1) * a1) / 7;
      if (ai == 6) return 0;
      if (ai == 7) return 255;
      return ((6 - ai) * a0 + (ai - 1) * a1) / 5;
    endfunction

    // works out the four rows of one accepted block and queues them
    function void decode_block(input logic [63:0] colour, alpha, input logic [1:0] fmt);
      logic [31:0] pal [4];
      logic [31:0] t;
      texel_row_t r;
      bit three;
      int i, row, col, ai;
      three = (fmt == FMT_DXT1) && (colour[15:0] <= colour[31:16]);
      pal[0] = expand565(colour[15:0]);
      pal[1] = expand565(colour[31:16]);
      if (three) begin
        pal[2] = mix(pal[0], pal[1], 1, 1, 2);
        pal[3] = '0;
      end else begin
        pal[2] = mix(pal[0], pal[1], 2, 1, 3);
        pal[3] = mix(pal[0], pal[1], 1, 2, 3);
      end
      for (row = 0; row < 4; row++) begin
        r.row = 2'(row);
        r.last = (r.row == ROW_LAST);
        for (col = 0; col < COLS; col++) begin
          i = row * COLS + col;
          t = pal[colour[32 + 2 * i +: 2]];
          if (fmt == FMT_DXT3) begin
            t[31:24] = 8'(alpha[4 * i +: 4] * 17);
          end else if (fmt[1]) begin
            ai = alpha[16 + 3 * i +: 3];
            t[31:24] = 8'(alpha_level(alpha[7:0], alpha[15:8], ai));
          end
          r.texel[col] = t;
        end
        rows_due.push_back(r);
      end
    endfunction

    function void flag(input string what, input logic [31:0] want, got);
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_row(input texel_row_t got);
      texel_row_t want;
      int col;
      if (rows_due.size() == 0) begin
        flag("row_number (no row due)", 32'hffffffff, got.row);
        return;
      end
      want = rows_due.pop_front();
      if (got.row !== want.row) flag("row_number", want.row, got.row);
      for (col = 0; col < COLS; col++)
        if (got.texel[col] !== want.texel[col])
          flag($sformatf("texel_col%0d", col), want.texel[col], got.texel[col]);
      if (got.last !== want.last) flag("last_row", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_block_format;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_color_half;
  logic [63:0] in_alpha_half;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_row_number;
  logic [31:0] out_texel_col0;
  logic [31:0] out_texel_col1;
  logic [31:0] out_texel_col2;
  logic [31:0] out_texel_col3;
  logic        out_last_row;

  texel_row_board board;
  texel_row_t     seen_row;
  logic [1:0]     fmt_now;
  bit             tx_steady;
  bit             rx_steady;
  bit             hold_req;

  dxt_texture_block_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_block_format (cfg_block_format),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_color_half    (in_color_half),
    .in_alpha_half    (in_alpha_half),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_number   (out_row_number),
    .out_texel_col0   (out_texel_col0),
    .out_texel_col1   (out_texel_col1),
    .out_texel_col2   (out_texel_col2),
    .out_texel_col3   (out_texel_col3),
    .out_last_row     (out_last_row)
  );

  always #1 clk = ~clk;

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // DXT5 alpha half with indices 0..7 then 7..0 across the block
  function automatic logic [63:0] alpha_ramp(input logic [7:0] a0, a1);
    logic [63:0] r;
    int i;
    r = '0;
    r[7:0] = a0;
    r[15:8] = a1;
    for (i = 0; i < TEXELS; i++)
      r[16 + 3 * i +: 3] = (i < 8) ? 3'(i) : 3'(15 - i);
    return r;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] f);
    drain();
    cfg_valid <= 1'b1;
    cfg_block_format <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_now = f;
  endtask

  task automatic send_block(input logic [63:0] c, a, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_color_half <= c;
    in_alpha_half <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.decode_block(c, a, fmt_now);
  endtask

  task automatic random_block(output logic [63:0] c, a);
    logic [15:0] e0, e1, tmp;
    logic [31:0] idx;
    e0 = 16'($urandom);
    e1 = 16'($urandom);
    idx = $urandom;
    case ($urandom_range(0, 9))
      0: e1 = e0;
      1: begin
        e0 = 16'hffff;
        e1 = 16'h0000;
      end
      2, 3: if (e0 < e1) begin
        tmp = e0;
        e0 = e1;
        e1 = tmp;
      end
      4, 5: if (e0 > e1) begin
        tmp = e0;
        e0 = e1;
        e1 = tmp;
      end
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) idx = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
    c = {idx, e1, e0};
    a = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) a[15:8] = a[7:0];
    if ($urandom_range(0, 9) == 0) a[15:0] = $urandom_range(0, 1) ? 16'h00ff : 16'hff00;
  endtask

  // result side: short bursts with random stalls, or one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        stall = rx_steady ? 0 : idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_row.row = out_row_number;
      seen_row.texel[0] = out_texel_col0;
      seen_row.texel[1] = out_texel_col1;
      seen_row.texel[2] = out_texel_col2;
      seen_row.texel[3] = out_texel_col3;
      seen_row.last = out_last_row;
      board.check_row(seen_row);
    end
  end

  initial begin
    #LIMIT_TIME;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [1:0] fmt_plan [8];
    logic [63:0] c, a;
    int ph, n;
    fmt_plan = '{FMT_DXT1, FMT_DXT3, FMT_SPARE, FMT_DXT5,
                 FMT_DXT1, FMT_DXT5, FMT_DXT3, FMT_SPARE};
    board = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_block_format = FMT_DXT1;
    in_valid = 1'b0;
    in_color_half = '0;
    in_alpha_half = '0;
    out_ready = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    fmt_now = FMT_DXT1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // DXT1 straight from reset: equal endpoints, both orders, transparent black
    send_block(64'h0, 64'h0, 0);
    send_block(64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 0);
    send_block(64'he4e4e4e4_0000ffff, 64'h0, idle_len());
    send_block(64'he4e4e4e4_ffff0000, 64'h0, idle_len());
    send_block(64'h1b1b1b1b_07e0f800, {$urandom, $urandom}, 0);
    send_block(64'hb1e4_1b4e_f81f001f, {$urandom, $urandom}, idle_len());

    // explicit alpha, colour half always four-colour
    set_format(FMT_DXT3);
    send_block(64'he4e4e4e4_ffff0000, 64'hfedcba98_76543210, 0);
    send_block(64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 0);
    send_block(64'h0, 64'h0, idle_len());
    send_block(64'h4e1bb1e4_8410a554, 64'h0123456789abcdef, 0);

    // interpolated alpha: eight-entry, six-entry and equal endpoints
    set_format(FMT_DXT5);
    send_block(64'he4e4e4e4_0000ffff, alpha_ramp(8'hff, 8'h00), 0);
    send_block(64'he4e4e4e4_ffff0000, alpha_ramp(8'h00, 8'hff), 0);
    send_block({$urandom, $urandom}, alpha_ramp(8'h80, 8'h80), idle_len());
    send_block({$urandom, $urandom}, alpha_ramp(8'h37, 8'hc9), 0);
    send_block(64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 0);
    send_block(64'h0, 64'h0, 0);

    // spare code decodes as interpolated alpha
    set_format(FMT_SPARE);
    send_block({$urandom, $urandom}, alpha_ramp(8'hff, 8'h01), 0);
    send_block({$urandom, $urandom}, alpha_ramp(8'h10, 8'hf0), idle_len());

    set_format(FMT_DXT1);
    send_block(64'h1b1b1b1b_12341234, 64'h0, 0);
    send_block({$urandom, 32'h5555aaaa}, 64'h0, 0);

    for (ph = 0; ph < 8; ph++) begin
      set_format(fmt_plan[ph]);
      tx_steady = (ph == 1);
      rx_steady = (ph == 1);
      // long hold-off on the result side while blocks keep coming
      if (ph == 2) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain();
        random_block(c, a);
        send_block(c, a, tx_steady ? 0 : idle_len());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (board.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dxt_pkg.sv
hdl/dxt_blend_sums.sv
hdl/dxt_texel_sel.sv
hdl/dxt_texture_block_decoder.sv
test/tb_dxt_texture_block_decoder.sv
